### rtl/core/round_robin_wait_time_macros.svh
// assertion macros shared by the round-robin wait time checks
`ifndef ROUND_ROBIN_WAIT_TIME_MACROS_SVH
`define ROUND_ROBIN_WAIT_TIME_MACROS_SVH

// property that must hold at every clock edge out of reset
`define RRWT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("round robin wait time check failed");

// consequence that must hold on the clock after the trigger
`define RRWT_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("round robin wait time check failed");

`endif

### rtl/core/rrwt_pkg.sv
// types and constants for the round-robin wait time block
package rrwt_pkg;

  localparam int BURST_W    = 8;
  localparam int QUANTUM_W  = 8;
  localparam int TIME_W     = 12;
  localparam int TOTAL_W    = 16;
  localparam int JOB_IDX_W  = 4;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd3;

  // load, then schedule visits (read, update), then result beats
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCH_RD,
    ST_SCH_EX,
    ST_OUT_RD,
    ST_OUT_CALC,
    ST_OUT_SEND
  } rrwt_state_t;

endpackage

### rtl/core/rrwt_if.sv
// valid/ready channel interfaces for job bursts and per-job results
interface rrwt_in_if import rrwt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BURST_W-1:0] burst;
  logic               last_job;

  modport source (output valid, output burst, output last_job, input ready);
  modport sink   (input valid, input burst, input last_job, output ready);
endinterface

interface rrwt_out_if import rrwt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [JOB_IDX_W-1:0] job_index;
  logic [TIME_W-1:0]    wait_time;
  logic [TOTAL_W-1:0]   total_wait;
  logic                 last_result;

  modport source (output valid, output job_index, output wait_time,
                  output total_wait, output last_result, input ready);
  modport sink   (input valid, input job_index, input wait_time,
                  input total_wait, input last_result, output ready);
endinterface

### rtl/core/round_robin_wait_time.sv
// round-robin scheduler that reports per-job waiting time and a running total
//
// usage: send up to MAX_PROCS bursts, one beat each, with last_job on the final
// one; bursts beyond MAX_PROCS are dropped but a last_job mark still starts the
// run. every job arrives at time zero. the block then plays round-robin rounds
// of cfg_wdata-sized slices (a quantum of zero acts as one) and emits one result
// beat per loaded job in load order with its wait (completion minus burst) and
// the running sum of waits; last_result marks the final beat. loading takes
// each offered beat without stalling. each schedule visit, for every job in
// every round, reads the job's remaining time from the store and then updates
// it through the one shared min/subtract/add unit; with n jobs there are
// R = max(1, ceil(max_burst / quantum)) rounds of n visits. each result then
// passes a store read, the wait/total calculation and the output beat, which
// waits out any sink stall. in_ch.ready is low from the last_job beat until the
// final result beat is taken. the quantum register may only be written while idle.
module round_robin_wait_time
  import rrwt_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rrwt_in_if.sink              in_ch,
  rrwt_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [QUANTUM_W-1:0] cfg_wdata
);

  // store index and job counter widths (counter can hold MAX_PROCS itself)
  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // job stores: bursts, remaining ticks, completion times
  logic [BURST_W-1:0] burst_mem [MAX_PROCS];
  logic [BURST_W-1:0] rem_mem   [MAX_PROCS];
  logic [TIME_W-1:0]  fin_mem   [MAX_PROCS];

  // registered read data of the stores
  logic [BURST_W-1:0] bst_q;
  logic [BURST_W-1:0] rem_q;
  logic [TIME_W-1:0]  fin_q;

  rrwt_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;       // jobs held in this set
  logic [CNT_W-1:0]     job_r, job_nxt;       // job under visit or report
  logic [TIME_W-1:0]    clk_now_r, clk_now_nxt;
  logic [TOTAL_W-1:0]   tot_r, tot_nxt;
  logic                 first_r, first_nxt;   // still in the first round
  logic                 busy_r, busy_nxt;     // some job unfinished this round
  logic [QUANTUM_W-1:0] quantum_r;

  // result beat registers
  logic [JOB_IDX_W-1:0] o_idx_r, o_idx_nxt;
  logic [TIME_W-1:0]    o_wait_r, o_wait_nxt;
  logic [TOTAL_W-1:0]   o_tot_r, o_tot_nxt;
  logic                 o_last_r, o_last_nxt;

  // store write controls
  logic               bst_we;
  logic               rem_we;
  logic [IDX_W-1:0]   rem_widx;
  logic [BURST_W-1:0] rem_wdata;
  logic               fin_we;
  logic [TIME_W-1:0]  fin_wdata;
  logic [IDX_W-1:0]   job_idx;

  // shared slice unit
  logic [QUANTUM_W-1:0] q_eff;
  logic [BURST_W-1:0]   run_len;
  logic [BURST_W-1:0]   rem_left;
  logic [TIME_W-1:0]    clk_adv;
  logic                 busy_any;
  logic                 last_visit;

  // report unit
  logic [TIME_W-1:0]  wait_val;
  logic [TOTAL_W-1:0] tot_add;

  assign job_idx    = job_r[IDX_W-1:0];
  assign last_visit = (job_r + CNT_ONE) == cnt_r;

  assign q_eff    = (quantum_r == '0) ? QUANTUM_W'(1) : quantum_r;
  assign run_len  = (rem_q < q_eff) ? rem_q : q_eff;
  assign rem_left = rem_q - run_len;
  assign clk_adv  = clk_now_r + TIME_W'(run_len);

  // completion minus burst wraps at the wait width
  assign wait_val = fin_q - TIME_W'(bst_q);
  assign tot_add  = tot_r + TOTAL_W'(wait_val);

  assign in_ch.ready        = (state_r == ST_LOAD);
  assign out_ch.valid       = (state_r == ST_OUT_SEND);
  assign out_ch.job_index   = o_idx_r;
  assign out_ch.wait_time   = o_wait_r;
  assign out_ch.total_wait  = o_tot_r;
  assign out_ch.last_result = o_last_r;

  // quantum register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RESET;
    end else if (cfg_we) begin
      quantum_r <= cfg_wdata;
    end
  end

  // stores, written at one address and read at the current job
  always_ff @(posedge clk) begin
    if (bst_we) begin
      burst_mem[cnt_r[IDX_W-1:0]] <= in_ch.burst;
    end
    if (rem_we) begin
      rem_mem[rem_widx] <= rem_wdata;
    end
    if (fin_we) begin
      fin_mem[job_idx] <= fin_wdata;
    end
    bst_q <= burst_mem[job_idx];
    rem_q <= rem_mem[job_idx];
    fin_q <= fin_mem[job_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cnt_r     <= '0;
      job_r     <= '0;
      clk_now_r <= '0;
      tot_r     <= '0;
      first_r   <= 1'b0;
      busy_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      job_r     <= job_nxt;
      clk_now_r <= clk_now_nxt;
      tot_r     <= tot_nxt;
      first_r   <= first_nxt;
      busy_r    <= busy_nxt;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    o_idx_r  <= o_idx_nxt;
    o_wait_r <= o_wait_nxt;
    o_tot_r  <= o_tot_nxt;
    o_last_r <= o_last_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    job_nxt     = job_r;
    clk_now_nxt = clk_now_r;
    tot_nxt     = tot_r;
    first_nxt   = first_r;
    busy_nxt    = busy_r;
    o_idx_nxt   = o_idx_r;
    o_wait_nxt  = o_wait_r;
    o_tot_nxt   = o_tot_r;
    o_last_nxt  = o_last_r;
    bst_we      = 1'b0;
    rem_we      = 1'b0;
    rem_widx    = job_idx;
    rem_wdata   = rem_left;
    fin_we      = 1'b0;
    fin_wdata   = clk_adv;
    busy_any    = busy_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_ch.valid) begin
          // full store drops the burst
          if (cnt_r < CNT_MAX) begin
            bst_we    = 1'b1;
            rem_we    = 1'b1;
            rem_widx  = cnt_r[IDX_W-1:0];
            rem_wdata = in_ch.burst;
            cnt_nxt   = cnt_r + CNT_ONE;
          end
          if (in_ch.last_job) begin
            job_nxt     = '0;
            clk_now_nxt = '0;
            first_nxt   = 1'b1;
            busy_nxt    = 1'b0;
            state_nxt   = ST_SCH_RD;
          end
        end
      end

      ST_SCH_RD: begin
        state_nxt = ST_SCH_EX;
      end

      ST_SCH_EX: begin
        if (rem_q == '0) begin
          // zero burst finishes when its first-round turn comes
          fin_we    = first_r;
          fin_wdata = clk_now_r;
        end else begin
          rem_we      = 1'b1;
          clk_now_nxt = clk_adv;
          if (rem_left == '0) begin
            fin_we = 1'b1;
          end else begin
            busy_any = 1'b1;
          end
        end
        busy_nxt = busy_any;
        if (last_visit) begin
          job_nxt = '0;
          if (busy_any) begin
            first_nxt = 1'b0;
            busy_nxt  = 1'b0;
            state_nxt = ST_SCH_RD;
          end else begin
            tot_nxt   = '0;
            state_nxt = ST_OUT_RD;
          end
        end else begin
          job_nxt   = job_r + CNT_ONE;
          state_nxt = ST_SCH_RD;
        end
      end

      ST_OUT_RD: begin
        state_nxt = ST_OUT_CALC;
      end

      ST_OUT_CALC: begin
        o_idx_nxt  = JOB_IDX_W'(job_r);
        o_wait_nxt = wait_val;
        o_tot_nxt  = tot_add;
        o_last_nxt = last_visit;
        tot_nxt    = tot_add;
        state_nxt  = ST_OUT_SEND;
      end

      ST_OUT_SEND: begin
        if (out_ch.ready) begin
          if (o_last_r) begin
            // set done: empty for the next one
            cnt_nxt     = '0;
            job_nxt     = '0;
            clk_now_nxt = '0;
            state_nxt   = ST_LOAD;
          end else begin
            job_nxt   = job_r + CNT_ONE;
            state_nxt = ST_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

### rtl/core/rrwt_checker.sv
// port-level checks for the round-robin wait time block, with its bind
`include "round_robin_wait_time_macros.svh"

module rrwt_checker
  import rrwt_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_last_job,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [JOB_IDX_W-1:0] out_job_index,
  input logic [TIME_W-1:0]    out_wait_time,
  input logic [TOTAL_W-1:0]   out_total_wait,
  input logic                 out_last_result
);

  // whole result payload, for the hold check
  logic [JOB_IDX_W+TIME_W+TOTAL_W:0] out_beat;

  assign out_beat = {out_job_index, out_wait_time, out_total_wait, out_last_result};

  // loading and reporting never overlap
  `RRWT_ASSERT_ALWAYS(a_no_load_while_report, !(in_ready && out_valid))

  // an accepted final job beat closes the input
  `RRWT_ASSERT_NEXT(a_last_job_blocks_input, in_valid && in_ready && in_last_job, !in_ready)

  // the final result beat reopens the input at once
  `RRWT_ASSERT_NEXT(a_last_result_reopens, out_valid && out_ready && out_last_result, in_ready)

  // a stalled result holds
  `RRWT_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(out_beat))

endmodule

bind round_robin_wait_time rrwt_checker u_rrwt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_last_job     (in_ch.last_job),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_job_index   (out_ch.job_index),
  .out_wait_time   (out_ch.wait_time),
  .out_total_wait  (out_ch.total_wait),
  .out_last_result (out_ch.last_result)
);
